// ===== hw/rtl/sct_pkg.sv =====
// Package for the scroll camera tracker: field widths, register indexes
// and reset values shared by the top level and its checker.
// No dependencies.
package sct_pkg;

	// Field widths
	localparam int unsigned XW      = 16;
	localparam int unsigned VELW    = 12;
	localparam int unsigned SCROLLW = 15;
	localparam int unsigned COLW    = 14;
	localparam int unsigned WIDTHW  = 10;
	localparam int unsigned SPEEDW  = 4;
	localparam int unsigned CFG_IW  = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IW-1:0] {
		CFG_SCREEN_WIDTH = 2'd0,
		CFG_CHASE_SPEED  = 2'd1
	} cfg_index_t;

	// Register reset values
	localparam logic [WIDTHW-1:0] SCREEN_WIDTH_RST = 10'd320;
	localparam logic [SPEEDW-1:0] CHASE_SPEED_RST  = 4'd4;

	// Largest scroll value
	localparam logic [SCROLLW-1:0] SCROLL_MAX = 15'h7fff;

endpackage

// ===== hw/rtl/scroll_camera_tracker_top.sv =====
// Horizontal scroll camera tracker: follows a tracked object and reports
// tile columns that must be loaded. Depends on sct_pkg.
//
// Usage:
//   Input channel (target_valid / target_stall) carries one word per frame
//   tick: the object's level x position and its horizontal velocity.
//   Output channel (result_valid / result_stall) returns one word per input
//   word: scroll position, column load request and lock flag.
//   Configuration channel (cfg_valid / cfg_ready, always ready) writes
//   screen_width (index 0) and chase_speed (index 1); writes must be made
//   only while no word is in flight.
// Pipeline and throughput:
//   A word is held in the input register, passes through the combinational
//   logic against the camera state, and its result loads into the result
//   register when free. One word per cycle is sustained unless stalled.
// Stall and reset:
//   When the receiver stalls, the result register holds its word and the
//   input register fills; target_stall rises only when both are full.
//   Reset clears the camera state, the valid flags and restores the
//   registers to screen width 320 and chase speed 4.
module scroll_camera_tracker_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input channel
	input  logic                                target_valid,
	output logic                                target_stall,
	input  logic signed [sct_pkg::XW-1:0]       target_x,
	input  logic signed [sct_pkg::VELW-1:0]     target_vel_x,
	// Output channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic        [sct_pkg::SCROLLW-1:0]  scroll_x,
	output logic                                column_pending,
	output logic signed [sct_pkg::COLW-1:0]     column_index,
	output logic                                locked,
	// Configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [sct_pkg::CFG_IW-1:0]   cfg_index,
	input  logic        [sct_pkg::WIDTHW-1:0]   cfg_data
);
	import sct_pkg::*;

	// Configuration registers
	logic [WIDTHW-1:0] screen_width_q;
	logic [SPEEDW-1:0] chase_speed_q;

	// Camera state
	logic [SCROLLW-1:0] scroll_q;
	logic [SCROLLW-1:0] last_scroll_q;
	logic               chasing_q;
	logic               from_left_q;
	logic               lock_q;
	logic               moving_left_q;

	// Input register stage
	logic                   valid_s1;
	logic signed [XW-1:0]   x_s1;
	logic signed [VELW-1:0] vel_s1;

	// Result register stage
	logic                   valid_s2;
	logic [SCROLLW-1:0]     scroll_s2;
	logic                   pending_s2;
	logic [COLW-1:0]        column_s2;
	logic                   locked_s2;

	// Flow control
	logic out_load;
	logic advance;
	logic in_accept;

	// Next-state values from the processing pass
	logic [SCROLLW-1:0] scroll_n;
	logic               chasing_n;
	logic               from_left_n;
	logic               lock_n;
	logic               moving_left_n;
	logic               pending_n;
	logic [COLW-1:0]    column_n;

	// Derived screen geometry
	logic [WIDTHW-1:0]   center;
	logic [WIDTHW-1:0]   pad;
	logic [WIDTHW-1:0]   right_bound;
	logic [WIDTHW+10:0]  pad_prod;

	assign out_load     = !valid_s2 || !result_stall;
	assign advance      = valid_s1 && out_load;
	assign in_accept    = target_valid && !target_stall;
	assign target_stall = valid_s1 && !out_load;
	assign cfg_ready    = 1'b1;

	// Width / 3 as a multiply by the reciprocal 683/2048, exact for 10 bits.
	assign pad_prod    = {11'd0, screen_width_q} * (WIDTHW + 11)'(683);
	assign pad         = pad_prod[WIDTHW+10:11];
	assign center      = {1'b0, screen_width_q[WIDTHW-1:1]};
	assign right_bound = screen_width_q - pad;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
			chase_speed_q  <= CHASE_SPEED_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH: screen_width_q <= cfg_data;
				CFG_CHASE_SPEED:  chase_speed_q  <= cfg_data[SPEEDW-1:0];
				default: ;
			endcase
		end
	end

	// Processing pass: direction check, chase start, step, lock and clamp,
	// then the column boundary test.
	always_comb begin
		logic signed [18:0] xe;
		logic signed [18:0] se;
		logic signed [18:0] sx;
		logic signed [18:0] ce;
		logic signed [18:0] spd;
		logic               turned;
		logic [COLW-1:0]    col_base;

		xe  = {{3{x_s1[XW-1]}}, x_s1};
		ce  = {9'd0, center};
		spd = {15'd0, chase_speed_q};
		se  = {4'd0, scroll_q};
		sx  = xe - se;

		chasing_n   = chasing_q;
		from_left_n = from_left_q;
		lock_n      = lock_q;

		turned = (vel_s1 != '0) && (moving_left_q != vel_s1[VELW-1]);

		// A turn cancels the chase; otherwise an idle camera may start one.
		if (turned) begin
			chasing_n = 1'b0;
			lock_n    = 1'b0;
		end else if (!chasing_q) begin
			if (sx > $signed({9'd0, right_bound})) begin
				chasing_n   = 1'b1;
				from_left_n = 1'b0;
			end else if (sx < $signed({9'd0, pad})) begin
				chasing_n   = 1'b1;
				from_left_n = 1'b1;
			end
			lock_n = 1'b0;
		end

		// Step toward the object, lock once its screen x crosses center.
		if (chasing_n) begin
			if (!from_left_n && (sx > ce)) begin
				se     = se + spd;
				lock_n = !((xe - se) > ce);
			end else if (from_left_n && (sx < ce)) begin
				se     = se - spd;
				lock_n = !((xe - se) < ce);
			end
			if (lock_n) begin
				se = xe - ce;
			end
			if (se < 0) begin
				se        = '0;
				lock_n    = 1'b0;
				chasing_n = 1'b0;
			end
			if (se > $signed({4'd0, SCROLL_MAX})) begin
				scroll_n = SCROLL_MAX;
			end else begin
				scroll_n = se[SCROLLW-1:0];
			end
		end else begin
			scroll_n = scroll_q;
		end

		if (vel_s1 != '0) begin
			moving_left_n = vel_s1[VELW-1];
		end else begin
			moving_left_n = moving_left_q;
		end

		// Column load when scroll moves into another 8-pixel column.
		col_base  = {2'd0, scroll_n[SCROLLW-1:3]};
		pending_n = scroll_n[SCROLLW-1:3] != last_scroll_q[SCROLLW-1:3];
		if (!pending_n) begin
			column_n = '0;
		end else if (scroll_n < last_scroll_q) begin
			column_n = col_base - COLW'(1);
		end else begin
			column_n = col_base + {7'd0, screen_width_q[WIDTHW-1:3]} + COLW'(1);
		end
	end

	// Camera state and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_q      <= '0;
			last_scroll_q <= '0;
			chasing_q     <= 1'b0;
			from_left_q   <= 1'b0;
			lock_q        <= 1'b0;
			moving_left_q <= 1'b0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
		end else begin
			if (advance) begin
				scroll_q      <= scroll_n;
				chasing_q     <= chasing_n;
				from_left_q   <= from_left_n;
				lock_q        <= lock_n;
				moving_left_q <= moving_left_n;
				if (pending_n) begin
					last_scroll_q <= scroll_n;
				end
			end
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_s1   <= target_x;
			vel_s1 <= target_vel_x;
		end
		if (advance) begin
			scroll_s2  <= scroll_n;
			pending_s2 <= pending_n;
			column_s2  <= column_n;
			locked_s2  <= lock_n;
		end
	end

	assign result_valid   = valid_s2;
	assign scroll_x       = scroll_s2;
	assign column_pending = pending_s2;
	assign column_index   = $signed(column_s2);
	assign locked         = locked_s2;

endmodule

// ===== hw/rtl/sct_checker.sv =====
// Port-level checker for the scroll camera tracker, bound to the top level.
// Depends on sct_pkg and scroll_camera_tracker_top.
module sct_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                target_valid,
	input logic                                target_stall,
	input logic signed [sct_pkg::XW-1:0]       target_x,
	input logic signed [sct_pkg::VELW-1:0]     target_vel_x,
	input logic                                result_valid,
	input logic                                result_stall,
	input logic        [sct_pkg::SCROLLW-1:0]  scroll_x,
	input logic                                column_pending,
	input logic signed [sct_pkg::COLW-1:0]     column_index,
	input logic                                locked,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic        [sct_pkg::CFG_IW-1:0]   cfg_index,
	input logic        [sct_pkg::WIDTHW-1:0]   cfg_data
);
	import sct_pkg::*;

	// No column request means a zero column index.
	a_column_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !column_pending |-> column_index == '0)
		else $error("column_index nonzero without column_pending");

	// A request for column -1 only happens at the far left of the level.
	a_column_left: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && column_pending && column_index == -14'sd1 |-> scroll_x < 15'd8)
		else $error("column -1 requested away from the left edge");

	// The input stalls only when the result word is held by the receiver.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		target_stall |-> result_valid && result_stall)
		else $error("input stalled while the output side can move");

	// A stalled result word holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(scroll_x)
			&& $stable(column_pending) && $stable(column_index) && $stable(locked))
		else $error("stalled result word changed");

endmodule

bind scroll_camera_tracker_top sct_checker u_sct_checker (.*);
